FILE: rtl/cct_pkg.sv
// Shared types and constants for the character class tokenizer.
// Used by cct_scan, cct_outq and character_class_tokenizer_unit; no dependencies.
package cct_pkg;

	typedef enum logic [2:0] {
		CLS_IDENT  = 3'd0,
		CLS_NUMBER = 3'd1,
		CLS_DELIM  = 3'd2,
		CLS_SYMBOL = 3'd3,
		CLS_END    = 3'd4
	} tok_class_t;

	typedef enum logic [1:0] {
		OPEN_NONE   = 2'd0,
		OPEN_IDENT  = 2'd1,
		OPEN_NUMBER = 2'd2
	} open_class_t;

	localparam int START_W = 32;
	localparam int LEN_W   = 16;
	localparam int LINES_W = 32;

	localparam logic [7:0] ASCII_TAB    = 8'h09;
	localparam logic [7:0] ASCII_LF     = 8'h0A;
	localparam logic [7:0] ASCII_CR     = 8'h0D;
	localparam logic [7:0] ASCII_SPACE  = 8'h20;
	localparam logic [7:0] ASCII_COMMA  = 8'h2C;
	localparam logic [7:0] ASCII_DASH   = 8'h2D;
	localparam logic [7:0] ASCII_PERIOD = 8'h2E;

	// result queue depth: room for two results of one byte plus two already queued
	localparam int QUEUE_DEPTH = 4;
	localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		tok_class_t            cls;
		logic [START_W-1:0]    start;
		logic [LEN_W-1:0]      length;
		logic [7:0]            first;
		logic [LINES_W-1:0]    lines;
		logic                  last;
	} result_t;

endpackage

FILE: rtl/cct_scan.sv
// Input register and token scanner: open-token state and up to two results per beat.
// Depends on cct_pkg.
module cct_scan #(
	parameter int LENGTH_BITS   = 16,
	parameter int POSITION_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  logic                  command,
	input  logic [7:0]            data_byte,
	input  logic                  room,
	output logic                  item_stall,
	output logic                  busy,
	output logic                  go,
	output logic [1:0]            n_res,
	output cct_pkg::result_t      res0,
	output cct_pkg::result_t      res1
);

	logic                         valid_s1;
	logic                         command_s1;
	logic [7:0]                   byte_s1;

	cct_pkg::open_class_t         open_q, open_n;
	logic [LENGTH_BITS-1:0]       len_q, len_n;
	logic [POSITION_BITS-1:0]     start_q, start_n;
	logic [7:0]                   first_q, first_n;
	logic                         period_q, period_n;
	logic [cct_pkg::LINES_W-1:0]  lines_q, lines_n;
	logic [POSITION_BITS-1:0]     pos_q, pos_n;

	logic                         is_ws, is_lf, is_letter, is_digit, is_dot, is_dash;
	logic                         starts, lone;
	cct_pkg::result_t             flush_r, begin_r, end_r;

	assign go         = valid_s1 & room;
	assign item_stall = valid_s1 & ~room;
	assign busy       = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			command_s1 <= command;
			byte_s1    <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q   <= cct_pkg::OPEN_NONE;
			len_q    <= '0;
			start_q  <= '0;
			first_q  <= '0;
			period_q <= 1'b0;
			lines_q  <= '0;
			pos_q    <= '0;
		end else if (go) begin
			open_q   <= open_n;
			len_q    <= len_n;
			start_q  <= start_n;
			first_q  <= first_n;
			period_q <= period_n;
			lines_q  <= lines_n;
			pos_q    <= pos_n;
		end
	end

	assign is_ws     = (byte_s1 == cct_pkg::ASCII_TAB) || (byte_s1 == cct_pkg::ASCII_CR) ||
	                   (byte_s1 == cct_pkg::ASCII_SPACE);
	assign is_lf     = (byte_s1 == cct_pkg::ASCII_LF);
	assign is_letter = ((byte_s1 >= 8'h41) && (byte_s1 <= 8'h5A)) ||
	                   ((byte_s1 >= 8'h61) && (byte_s1 <= 8'h7A));
	assign is_digit  = (byte_s1 >= 8'h30) && (byte_s1 <= 8'h39);
	assign is_dot    = (byte_s1 == cct_pkg::ASCII_PERIOD);
	assign is_dash   = (byte_s1 == cct_pkg::ASCII_DASH);
	assign starts    = is_letter | is_digit | is_dot | is_dash;
	assign lone      = (open_q == cct_pkg::OPEN_NUMBER) && (len_q == LENGTH_BITS'(1)) &&
	                   ((first_q == cct_pkg::ASCII_PERIOD) || (first_q == cct_pkg::ASCII_DASH));

	always_comb begin
		flush_r.cls    = (open_q == cct_pkg::OPEN_IDENT) ? cct_pkg::CLS_IDENT
		                                                 : cct_pkg::CLS_NUMBER;
		flush_r.start  = cct_pkg::START_W'(start_q);
		flush_r.length = cct_pkg::LEN_W'(len_q);
		flush_r.first  = first_q;
		flush_r.lines  = lines_q;
		flush_r.last   = 1'b0;

		begin_r.cls    = (byte_s1 == cct_pkg::ASCII_COMMA) ? cct_pkg::CLS_DELIM
		                                                   : cct_pkg::CLS_SYMBOL;
		begin_r.start  = cct_pkg::START_W'(pos_q);
		begin_r.length = cct_pkg::LEN_W'(1);
		begin_r.first  = byte_s1;
		begin_r.lines  = lines_q;
		begin_r.last   = 1'b0;

		end_r.cls      = cct_pkg::CLS_END;
		end_r.start    = cct_pkg::START_W'(pos_q);
		end_r.length   = '0;
		end_r.first    = '0;
		end_r.lines    = lines_q;
		end_r.last     = 1'b0;
	end

	always_comb begin
		open_n   = open_q;
		len_n    = len_q;
		start_n  = start_q;
		first_n  = first_q;
		period_n = period_q;
		lines_n  = lines_q;
		pos_n    = pos_q + POSITION_BITS'(1);
		res0     = flush_r;
		res1     = end_r;
		n_res    = 2'd0;

		if (command_s1) begin
			// flush the open token, report end of text, clear everything
			if (open_q != cct_pkg::OPEN_NONE) begin
				n_res = 2'd2;
			end else begin
				res0  = end_r;
				n_res = 2'd1;
			end
			open_n   = cct_pkg::OPEN_NONE;
			len_n    = '0;
			start_n  = '0;
			first_n  = '0;
			period_n = 1'b0;
			lines_n  = '0;
			pos_n    = '0;
		end else if (open_q == cct_pkg::OPEN_NONE) begin
			if (is_lf) begin
				lines_n = lines_q + cct_pkg::LINES_W'(1);
			end else if (starts) begin
				open_n   = is_letter ? cct_pkg::OPEN_IDENT : cct_pkg::OPEN_NUMBER;
				len_n    = LENGTH_BITS'(1);
				start_n  = pos_q;
				first_n  = byte_s1;
				period_n = is_dot;
			end else if (!is_ws) begin
				res0  = begin_r;
				n_res = 2'd1;
			end
		end else if (is_lf || is_ws ||
		             !(is_digit || (is_letter && open_q == cct_pkg::OPEN_IDENT) ||
		               (is_dot && open_q == cct_pkg::OPEN_NUMBER && !period_q))) begin
			// token ends here
			n_res    = 2'd1;
			open_n   = cct_pkg::OPEN_NONE;
			len_n    = '0;
			start_n  = '0;
			first_n  = '0;
			period_n = 1'b0;
			if (is_lf) begin
				lines_n       = lines_q + cct_pkg::LINES_W'(1);
				res0.lines    = lines_n;
			end else begin
				if (lone) begin
					res0.cls = cct_pkg::CLS_SYMBOL;
				end
				if (!is_ws) begin
					// rescan the ending byte as the start of the next token
					if (starts) begin
						open_n   = is_letter ? cct_pkg::OPEN_IDENT : cct_pkg::OPEN_NUMBER;
						len_n    = LENGTH_BITS'(1);
						start_n  = pos_q;
						first_n  = byte_s1;
						period_n = is_dot;
					end else begin
						res1  = begin_r;
						n_res = 2'd2;
					end
				end
			end
		end else begin
			if (len_q != '1) begin
				len_n = len_q + LENGTH_BITS'(1);
			end
			if (is_dot) begin
				period_n = 1'b1;
			end
		end

		if (n_res == 2'd1) begin
			res0.last = 1'b1;
		end
		if (n_res == 2'd2) begin
			res1.last = 1'b1;
		end
	end

endmodule

FILE: rtl/cct_outq.sv
// Result queue: shift-down register queue taking up to two results a beat, one out.
// Depends on cct_pkg.
module cct_outq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic [1:0]                    n_res,
	input  cct_pkg::result_t              res0,
	input  cct_pkg::result_t              res1,
	input  logic                          token_stall,
	output logic                          room,
	output logic                          token_valid,
	output logic [cct_pkg::COUNT_W-1:0]   count,
	output cct_pkg::result_t              head
);

	cct_pkg::result_t                 q_q  [cct_pkg::QUEUE_DEPTH];
	cct_pkg::result_t                 q_n  [cct_pkg::QUEUE_DEPTH];
	cct_pkg::result_t                 sh   [cct_pkg::QUEUE_DEPTH];
	logic [cct_pkg::COUNT_W-1:0]      count_q, count_n, base;
	logic                             pop;

	assign token_valid = (count_q != '0);
	assign pop         = token_valid & ~token_stall;
	assign base        = count_q - cct_pkg::COUNT_W'(pop);
	assign room        = (base <= cct_pkg::COUNT_W'(cct_pkg::QUEUE_DEPTH - 2));
	assign count       = count_q;
	assign head        = q_q[0];

	always_comb begin
		for (int i = 0; i < cct_pkg::QUEUE_DEPTH - 1; i++) begin
			sh[i] = q_q[i + 1];
		end
		sh[cct_pkg::QUEUE_DEPTH - 1] = q_q[cct_pkg::QUEUE_DEPTH - 1];

		for (int i = 0; i < cct_pkg::QUEUE_DEPTH; i++) begin
			q_n[i] = pop ? sh[i] : q_q[i];
			if (push && n_res != 2'd0 && base == cct_pkg::COUNT_W'(i)) begin
				q_n[i] = res0;
			end
			if (push && n_res == 2'd2 && base + cct_pkg::COUNT_W'(1) == cct_pkg::COUNT_W'(i)) begin
				q_n[i] = res1;
			end
		end

		count_n = base + (push ? cct_pkg::COUNT_W'(n_res) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_n;
		end
	end

	always_ff @(posedge clk) begin
		q_q <= q_n;
	end

endmodule

FILE: rtl/character_class_tokenizer_unit.sv
// Top level of the character class tokenizer: scanner plus result queue.
// Depends on cct_pkg, cct_scan and cct_outq.
//
// Takes one text byte (or an end-of-text command) per beat and returns token
// descriptors. A byte is taken every cycle while the result queue has room for
// two more results; a result passes the input register and the queue before it
// leaves, and results drain one per cycle while token_stall is low, so the
// sustained rate is one byte per cycle as long as bytes cause at most one result
// on average. A byte that both closes a token and forms a lone symbol, and end of
// text with a token open, give two results, which the single-beat output port
// takes in turn. The input stalls only when the four-entry queue is backed up.
module character_class_tokenizer_unit #(
	parameter int LENGTH_BITS   = 16,
	parameter int POSITION_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_stall,
	input  logic         command,
	input  logic [7:0]   data_byte,
	output logic         token_valid,
	input  logic         token_stall,
	output logic [2:0]   token_class,
	output logic [31:0]  token_start,
	output logic [15:0]  token_length,
	output logic [7:0]   first_byte,
	output logic [31:0]  line_count,
	output logic         last
);

	logic                           room, go, busy;
	logic [1:0]                     n_res;
	logic [cct_pkg::COUNT_W-1:0]    count;
	cct_pkg::result_t               res0, res1, head;

	cct_scan #(
		.LENGTH_BITS   (LENGTH_BITS),
		.POSITION_BITS (POSITION_BITS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.command    (command),
		.data_byte  (data_byte),
		.room       (room),
		.item_stall (item_stall),
		.busy       (busy),
		.go         (go),
		.n_res      (n_res),
		.res0       (res0),
		.res1       (res1)
	);

	cct_outq u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (go),
		.n_res       (n_res),
		.res0        (res0),
		.res1        (res1),
		.token_stall (token_stall),
		.room        (room),
		.token_valid (token_valid),
		.count       (count),
		.head        (head)
	);

	assign token_class  = head.cls;
	assign token_start  = head.start;
	assign token_length = head.length;
	assign first_byte   = head.first;
	assign line_count   = head.lines;
	assign last         = head.last;

	// the queue never overfills
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count <= cct_pkg::COUNT_W'(cct_pkg::QUEUE_DEPTH))
		else $error("result queue overflow");

	// a stall at the input means a byte is held in the input register
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> busy)
		else $error("input stalled with empty input register");

	// the end token always closes its beat's results
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(token_valid && token_class == cct_pkg::CLS_END) |-> last)
		else $error("end token not marked last");

	// the partner of a non-last result is already queued
	a_pair_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(token_valid && !last) |=> token_valid)
		else $error("second result of a byte lost");

endmodule
